>>> sv/assert_macros.svh
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked property, muted while reset is high
`define ASSERT_RST(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
// Checked property, also checked during reset
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");
`else
`define ASSERT_RST(lbl, clk, rst, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

>>> sv/arpc_pkg.sv
package arpc_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_HW_TYPE    = 2'd0;
  localparam logic [1:0] REG_PROTO_TYPE = 2'd1;
  localparam logic [1:0] REG_HW_LEN     = 2'd2;
  localparam logic [1:0] REG_PROTO_LEN  = 2'd3;

  // Item kinds
  localparam logic KIND_LEARN  = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  // Valid ARP opcodes
  localparam logic [15:0] OP_REQUEST = 16'd1;
  localparam logic [15:0] OP_REPLY   = 16'd2;

  typedef struct packed {
    logic        kind;
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [7:0]  hw_len;
    logic [7:0]  proto_len;
    logic [15:0] opcode;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [31:0] target_ip;
    logic [31:0] query_ip;
  } arpc_in_t;

  typedef struct packed {
    logic        msg_valid;
    logic        learned;
    logic        table_full_drop;
    logic        hit;
    logic [47:0] mac_out;
    logic [4:0]  entry_count_out;
  } arpc_out_t;

endpackage

>>> sv/arpc_in_if.sv
interface arpc_in_if import arpc_pkg::*; ();
  logic     valid;
  logic     ready;
  arpc_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> sv/arpc_out_if.sv
interface arpc_out_if import arpc_pkg::*; ();
  logic      valid;
  logic      ready;
  arpc_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> sv/arp_cache_learn_lookup.sv
// ARP neighbor cache: learn from ARP message fields, look up MAC by IP.
// The scan reads the filled entries in order; a matching entry ends the scan
//   early, for a lookup or a learn. One entry is compared per cycle.
// A new item is accepted only in idle, after the last one's result is registered.
// Reset: fill count cleared, config registers set to defaults; entry memories
//   are not cleared, only entries below the count are read.
`include "assert_macros.svh"

module arp_cache_learn_lookup import arpc_pkg::*; #(
  parameter int CACHE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  arpc_in_if.sink     req,
  arpc_out_if.source  rsp
);

  localparam int CW = $clog2(CACHE_DEPTH + 1);
  localparam int AW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(CACHE_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  // Config registers
  logic [15:0] expected_hw_type;
  logic [15:0] expected_proto_type;
  logic [7:0]  expected_hw_len;
  logic [7:0]  expected_proto_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_hw_type    <= 16'd1;
      expected_proto_type <= 16'h0800;
      expected_hw_len     <= 8'd6;
      expected_proto_len  <= 8'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HW_TYPE:    expected_hw_type    <= cfg_data;
        REG_PROTO_TYPE: expected_proto_type <= cfg_data;
        REG_HW_LEN:     expected_hw_len     <= cfg_data[7:0];
        REG_PROTO_LEN:  expected_proto_len  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Control and item registers
  logic [1:0]    state;
  logic [CW-1:0] fill_count;
  logic [CW-1:0] issue_idx;
  logic          pend;
  logic          found;
  arpc_in_t      item;
  logic          out_valid;
  arpc_out_t     out_data;

  // Entry memories, registered read
  logic [31:0] ip_mem  [CACHE_DEPTH];
  logic [47:0] mac_mem [CACHE_DEPTH];
  logic [31:0] rd_ip;
  logic [47:0] rd_mac;
  logic        rd_en;
  logic        mem_we;

  logic        accept;
  logic        out_free;
  logic [31:0] key_ip;
  logic        match;
  logic        scan_end;
  logic        msg_ok;
  logic        is_learn;
  logic        room;
  arpc_out_t   result;

  // Hit MAC captured during the scan
  logic [47:0] out_data_mac_hold;

  assign accept   = req.valid && req.ready;
  assign out_free = !out_valid || rsp.ready;
  assign req.ready = (state == S_IDLE);
  assign rsp.valid   = out_valid;
  assign rsp.payload = out_data;

  assign key_ip   = (item.kind == KIND_LOOKUP) ? item.query_ip : item.sender_ip;
  assign rd_en    = (state == S_SCAN) && !found && (issue_idx < fill_count);
  assign match    = pend && (rd_ip == key_ip) && (rd_mac != 48'd0);
  assign scan_end = (state == S_SCAN) && (match || (!pend && !rd_en));

  // Message validity checks
  assign msg_ok = (item.hw_type == expected_hw_type)
               && (item.proto_type == expected_proto_type)
               && (item.hw_len == expected_hw_len)
               && (item.proto_len == expected_proto_len)
               && (item.opcode == OP_REQUEST || item.opcode == OP_REPLY)
               && (item.sender_mac != 48'd0)
               && (item.sender_ip != 32'd0)
               && (item.target_ip != 32'd0);

  assign is_learn = (item.kind == KIND_LEARN);
  assign room     = (fill_count < DEPTH_C);
  assign mem_we   = (state == S_FIN) && out_free && is_learn && msg_ok && !found && room;

  // Result assembly
  always_comb begin
    result                 = '0;
    result.msg_valid       = is_learn && msg_ok;
    result.learned         = mem_we;
    result.table_full_drop = is_learn && msg_ok && !found && !room;
    result.hit             = !is_learn && found;
    result.mac_out         = (!is_learn && found) ? out_data_mac_hold : 48'd0;
    result.entry_count_out = 5'(fill_count + CW'(mem_we));
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_ip  <= ip_mem[issue_idx[AW-1:0]];
      rd_mac <= mac_mem[issue_idx[AW-1:0]];
    end
    if (mem_we) begin
      ip_mem[fill_count[AW-1:0]]  <= item.sender_ip;
      mac_mem[fill_count[AW-1:0]] <= item.sender_mac;
    end
  end

  // Sequencer: scan entries one per cycle, then finish, writing back a newly learned entry
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_count <= '0;
      issue_idx  <= '0;
      pend       <= 1'b0;
      found      <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && !(state == S_FIN && out_free)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state     <= S_SCAN;
            issue_idx <= '0;
            pend      <= 1'b0;
            found     <= 1'b0;
          end
        end
        S_SCAN: begin
          pend <= rd_en && !scan_end;
          if (rd_en) begin
            issue_idx <= issue_idx + CW'(1);
          end
          if (match) begin
            found <= 1'b1;
          end
          if (scan_end) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
            if (mem_we) begin
              fill_count <= fill_count + CW'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= req.payload;
    end
    if (match) begin
      out_data_mac_hold <= rd_mac;
    end
    if (state == S_FIN && out_free) begin
      out_data <= result;
    end
  end

  `ASSERT_ALWAYS(a_reset_idle, clk, rst |=> (state == S_IDLE && !out_valid))
  `ASSERT_RST(a_fill_bound, clk, rst, fill_count <= DEPTH_C)
  `ASSERT_RST(a_we_room, clk, rst, mem_we |-> (fill_count < DEPTH_C))
  `ASSERT_RST(a_fill_step, clk, rst, mem_we |=> (fill_count == CW'($past(fill_count) + CW'(1))))
  `ASSERT_RST(a_learn_flags, clk, rst,
    (out_valid && out_data.learned) |-> (out_data.msg_valid && !out_data.hit))
  `ASSERT_RST(a_no_read_in_fin, clk, rst, (state == S_FIN) |-> !rd_en)

endmodule

>>> bench/arp_cache_learn_lookup_tb.sv
`timescale 1ns / 1ps

module arp_cache_learn_lookup_tb;
  import arpc_pkg::*;

  localparam int DEPTH = 16;
  localparam int SETTLE_CYCLES = DEPTH + 8;
  localparam int RUN_LIMIT_NS = 5_000_000;
  localparam int MAX_PRINTED = 50;

  // Ways to spoil an otherwise well-formed ARP message
  typedef enum int {
    FLAW_HW_TYPE,
    FLAW_PROTO_TYPE,
    FLAW_HW_LEN,
    FLAW_PROTO_LEN,
    FLAW_OPCODE,
    FLAW_SENDER_MAC,
    FLAW_SENDER_IP,
    FLAW_TARGET_IP
  } arp_flaw_e;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  arpc_in_if  req_if ();
  arpc_out_if rsp_if ();

  arp_cache_learn_lookup #(
    .CACHE_DEPTH (DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_if),
    .rsp       (rsp_if)
  );

  // Mirror of the neighbor table and the expected-field registers
  logic [31:0] cache_ip  [DEPTH];
  logic [47:0] cache_mac [DEPTH];
  int unsigned cache_fill;
  logic [15:0] want_hw_type;
  logic [15:0] want_proto_type;
  logic [7:0]  want_hw_len;
  logic [7:0]  want_proto_len;

  arpc_out_t   answers_due[$];
  int unsigned mismatches;
  int          src_idle_pct;
  int          sink_stall_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Verification failed");
    $finish;
  end

  // Search the valid entries for an IP
  function automatic bit cache_find(input logic [31:0] ip, output logic [47:0] mac);
    mac = '0;
    for (int i = 0; i < cache_fill; i++) begin
      if (cache_ip[i] == ip && cache_mac[i] != '0) begin
        mac = cache_mac[i];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Learn or look up one item; updates the mirror, returns the answer
  function automatic arpc_out_t arp_cache_step(input arpc_in_t m);
    arpc_out_t   r;
    logic [47:0] found;
    bit          ok;
    r = '0;
    if (m.kind == KIND_LEARN) begin
      ok = (m.hw_type == want_hw_type) && (m.proto_type == want_proto_type) &&
           (m.hw_len == want_hw_len) && (m.proto_len == want_proto_len) &&
           (m.opcode == OP_REQUEST || m.opcode == OP_REPLY) &&
           (m.sender_mac != '0) && (m.sender_ip != '0) && (m.target_ip != '0);
      if (ok) begin
        r.msg_valid = 1'b1;
        if (!cache_find(m.sender_ip, found)) begin
          if (cache_fill < DEPTH) begin
            cache_ip[cache_fill]  = m.sender_ip;
            cache_mac[cache_fill] = m.sender_mac;
            cache_fill++;
            r.learned = 1'b1;
          end else begin
            r.table_full_drop = 1'b1;
          end
        end
      end
    end else begin
      r.hit     = cache_find(m.query_ip, found);
      r.mac_out = found;
    end
    r.entry_count_out = 5'(cache_fill);
    return r;
  endfunction

  function automatic logic [47:0] rand_mac_nz();
    logic [47:0] v;
    do v = {16'($urandom), 32'($urandom)}; while (v == '0);
    return v;
  endfunction

  function automatic logic [31:0] rand_ip_nz();
    return $urandom_range(32'hFFFF_FFFF, 1);
  endfunction

  // Nonzero IP not yet in the table
  function automatic logic [31:0] fresh_ip();
    logic [31:0] ip;
    logic [47:0] unused_mac;
    do ip = rand_ip_nz(); while (cache_find(ip, unused_mac));
    return ip;
  endfunction

  function automatic logic [31:0] cached_ip();
    if (cache_fill == 0) return rand_ip_nz();
    return cache_ip[$urandom_range(cache_fill - 1)];
  endfunction

  function automatic arpc_in_t noise_item();
    logic [223:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return arpc_in_t'(bits[$bits(arpc_in_t)-1:0]);
  endfunction

  // Well-formed message under the current settings
  function automatic arpc_in_t learn_beat(input logic [15:0] op, input logic [47:0] mac,
                                          input logic [31:0] sip, input logic [31:0] tip);
    arpc_in_t m;
    m            = noise_item();
    m.kind       = KIND_LEARN;
    m.hw_type    = want_hw_type;
    m.proto_type = want_proto_type;
    m.hw_len     = want_hw_len;
    m.proto_len  = want_proto_len;
    m.opcode     = op;
    m.sender_mac = mac;
    m.sender_ip  = sip;
    m.target_ip  = tip;
    return m;
  endfunction

  // Lookup; message fields carry junk the block must ignore
  function automatic arpc_in_t arp_query(input logic [31:0] ip);
    arpc_in_t m;
    m          = noise_item();
    m.kind     = KIND_LOOKUP;
    m.query_ip = ip;
    return m;
  endfunction

  function automatic arpc_in_t apply_flaw(input arpc_in_t m, input arp_flaw_e flaw);
    case (flaw)
      FLAW_HW_TYPE:    m.hw_type    = m.hw_type ^ 16'($urandom_range(16'hFFFF, 1));
      FLAW_PROTO_TYPE: m.proto_type = m.proto_type ^ 16'($urandom_range(16'hFFFF, 1));
      FLAW_HW_LEN:     m.hw_len     = m.hw_len ^ 8'($urandom_range(8'hFF, 1));
      FLAW_PROTO_LEN:  m.proto_len  = m.proto_len ^ 8'($urandom_range(8'hFF, 1));
      FLAW_OPCODE:     m.opcode     = $urandom_range(1) ? 16'($urandom_range(16'hFFFF, 3))
                                                        : 16'h0000;
      FLAW_SENDER_MAC: m.sender_mac = '0;
      FLAW_SENDER_IP:  m.sender_ip  = '0;
      FLAW_TARGET_IP:  m.target_ip  = '0;
      default: ;
    endcase
    return m;
  endfunction

  // Mostly well-formed learns and lookups, some broken messages and noise
  function automatic arpc_in_t random_item();
    int          sel;
    logic [31:0] ip;
    arpc_in_t    m;
    sel = $urandom_range(99);
    if (sel < 12) begin
      m = noise_item();
    end else if (sel < 50) begin
      sel = $urandom_range(9);
      if (sel < 6) ip = cached_ip();
      else if (sel < 9) ip = $urandom;
      else ip = '0;
      m = arp_query(ip);
    end else begin
      ip = ($urandom_range(99) < 35) ? cached_ip() : rand_ip_nz();
      m = learn_beat($urandom_range(1) ? OP_REQUEST : OP_REPLY, rand_mac_nz(), ip,
                     rand_ip_nz());
      if ($urandom_range(99) < 20)
        m = apply_flaw(m, arp_flaw_e'($urandom_range(FLAW_TARGET_IP)));
    end
    return m;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("%0t mismatch: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [47:0] got,
                             input logic [47:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // Send one beat, honoring the sender idle rate
  task automatic send_item(input arpc_in_t m);
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk);
      req_if.valid <= 1'b0;
    end
    @(negedge clk);
    req_if.valid   <= 1'b1;
    req_if.payload <= m;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    answers_due.push_back(arp_cache_step(m));
  endtask

  // Stop sending and wait until every answer is back
  task automatic go_quiet(input int settle);
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Write all four registers; length registers get junk in the upper byte
  task automatic set_config(input logic [15:0] hw, input logic [15:0] proto,
                            input logic [7:0] hwl, input logic [7:0] pl);
    go_quiet(4);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_HW_TYPE;
    cfg_data  <= hw;
    @(negedge clk);
    cfg_index <= REG_PROTO_TYPE;
    cfg_data  <= proto;
    @(negedge clk);
    cfg_index <= REG_HW_LEN;
    cfg_data  <= {8'($urandom), hwl};
    @(negedge clk);
    cfg_index <= REG_PROTO_LEN;
    cfg_data  <= {8'($urandom), pl};
    @(negedge clk);
    cfg_we <= 1'b0;
    want_hw_type    = hw;
    want_proto_type = proto;
    want_hw_len     = hwl;
    want_proto_len  = pl;
  endtask

  // All-zero and all-one items of both kinds
  task automatic test_field_extremes();
    arpc_in_t m;
    m = '0;
    send_item(m);
    m = '1;
    m.kind = KIND_LEARN;
    send_item(m);
    m = '0;
    m.kind = KIND_LOOKUP;
    send_item(m);
    m = '1;
    send_item(m);
  endtask

  // Each validity check failing on its own
  task automatic test_invalid_messages();
    arpc_in_t base;
    arpc_in_t m;
    base = learn_beat(OP_REQUEST, rand_mac_nz(), fresh_ip(), rand_ip_nz());
    for (int f = FLAW_HW_TYPE; f <= FLAW_TARGET_IP; f++)
      send_item(apply_flaw(base, arp_flaw_e'(f)));
    m = base;
    m.opcode = 16'h0000;
    send_item(m);
    m.opcode = 16'h0003;
    send_item(m);
    m.opcode = 16'hFFFF;
    send_item(m);
  endtask

  // Learn, duplicate sender, hits, misses and the zero query
  task automatic test_learn_and_lookup();
    logic [31:0] ip_a;
    logic [47:0] mac_a;
    ip_a  = fresh_ip();
    mac_a = rand_mac_nz();
    send_item(learn_beat(OP_REQUEST, mac_a, ip_a, rand_ip_nz()));
    send_item(learn_beat(OP_REPLY, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_item(learn_beat(OP_REPLY, 48'h1, 32'h1, 32'h1));
    // same sender, new MAC: entry must stay as first learned
    send_item(learn_beat(OP_REPLY, ~mac_a, ip_a, rand_ip_nz()));
    send_item(arp_query(ip_a));
    send_item(arp_query(32'hFFFF_FFFF));
    send_item(arp_query(32'h1));
    send_item(arp_query(fresh_ip()));
    send_item(arp_query(32'h0));
  endtask

  // A few items under the present settings
  task automatic config_probe();
    logic [31:0] ip;
    arpc_in_t    m;
    ip = fresh_ip();
    send_item(learn_beat(OP_REQUEST, rand_mac_nz(), ip, rand_ip_nz()));
    m = learn_beat(OP_REPLY, rand_mac_nz(), fresh_ip(), rand_ip_nz());
    m.proto_len = m.proto_len + 8'd1;
    send_item(m);
    send_item(arp_query(ip));
    send_item(learn_beat(OP_REPLY, rand_mac_nz(), fresh_ip(), rand_ip_nz()));
  endtask

  task automatic test_config_sweep();
    set_config(16'h0000, 16'h0000, 8'h00, 8'h00);
    config_probe();
    set_config(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
    config_probe();
    set_config(16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
    config_probe();
    set_config(16'd1, 16'h0800, 8'd6, 8'd4);
    config_probe();
  endtask

  task automatic test_random_traffic(input int src_pct, input int sink_pct, input int count);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    repeat (count) send_item(random_item());
  endtask

  // Fill every slot, then a new sender must be dropped
  task automatic test_table_full();
    while (cache_fill < DEPTH)
      send_item(learn_beat(OP_REQUEST, rand_mac_nz(), fresh_ip(), rand_ip_nz()));
    send_item(learn_beat(OP_REQUEST, rand_mac_nz(), fresh_ip(), rand_ip_nz()));
    send_item(learn_beat(OP_REPLY, rand_mac_nz(), cached_ip(), rand_ip_nz()));
    send_item(arp_query(cache_ip[DEPTH-1]));
  endtask

  // Receiver stall pattern
  always @(negedge clk) begin
    rsp_if.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Compare each result beat with the oldest expected answer
  always @(posedge clk) begin
    arpc_out_t want;
    if (!rst && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (answers_due.size() == 0) begin
        report_mismatch("result beat with no item outstanding");
      end else begin
        want = answers_due.pop_front();
        check_field("msg_valid", rsp_if.payload.msg_valid, want.msg_valid);
        check_field("learned", rsp_if.payload.learned, want.learned);
        check_field("table_full_drop", rsp_if.payload.table_full_drop,
                    want.table_full_drop);
        check_field("hit", rsp_if.payload.hit, want.hit);
        check_field("mac_out", rsp_if.payload.mac_out, want.mac_out);
        check_field("entry_count_out", rsp_if.payload.entry_count_out,
                    want.entry_count_out);
      end
    end
  end

  initial begin
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = REG_HW_TYPE;
    cfg_data        = '0;
    req_if.valid    = 1'b0;
    req_if.payload  = '0;
    rsp_if.ready    = 1'b0;
    mismatches      = 0;
    cache_fill      = 0;
    want_hw_type    = 16'd1;
    want_proto_type = 16'h0800;
    want_hw_len     = 8'd6;
    want_proto_len  = 8'd4;
    src_idle_pct    = 25;
    sink_stall_pct  = 59;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_field_extremes();
    test_invalid_messages();
    test_learn_and_lookup();
    test_config_sweep();
    test_random_traffic(25, 59, 600);
    set_config(16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
    test_random_traffic(59, 25, 600);
    set_config(16'd1, 16'h0800, 8'd6, 8'd4);
    test_random_traffic(0, 0, 600);
    test_table_full();

    go_quiet(SETTLE_CYCLES);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
